// ===== hw/rtl/qpr_pkg.sv =====
// Shared constants and helpers for the quaternion product and rotate block.
package qpr_pkg;

  // Width of every quaternion or vector field at the ports.
  localparam int unsigned IN_BITS = 32;

  // Operation codes carried on the func port.
  typedef enum logic {
    FUNC_PRODUCT = 1'b0,
    FUNC_ROTATE  = 1'b1
  } func_t;

  // Hamilton product: row i (w,x,y,z), term j uses a[j] * b[i ^ j].
  // Bit i*4+j set means that term is subtracted.
  localparam logic [15:0] HAM_NEG = 16'h428E;

  // Sign of term j in row i; conj flips every term whose b index is a vector part.
  function automatic logic term_neg(input int unsigned i, input int unsigned j,
                                    input logic conj);
    logic flip;
    flip = conj && ((i ^ j) != 0);
    return HAM_NEG[i*4 + j] ^ flip;
  endfunction

endpackage

// ===== hw/rtl/quaternion_product_and_rotate.sv =====
// Top level: quaternion Hamilton product and vector rotation, fully pipelined.
//
// Input channel (in_valid/in_ready) carries func and two quaternions a, b in
// signed fixed point with FRAC_BITS fraction bits. func FUNC_PRODUCT returns
// a*b; func FUNC_ROTATE returns a*(0,v)*conj(a) with v = (b_x,b_y,b_z),
// out_w = 0, and b_w ignored.
// Output channel (out_valid/out_ready) carries out_w..out_z and saturated,
// which flags a clipped component of pass 1 or, for rotation, of x..z in pass 2.
// Each transaction passes through two 4-stage product passes plus the output
// register on its way to out_valid. Both passes run for every transaction.
// Throughput: one transaction per cycle while the output is not stalled; each
// pass is multiply, pair add, final add, shift/saturate.
// The whole pipeline advances together: while out_valid is high and
// out_ready is low, every stage holds and in_ready is low, so nothing is
// lost or repeated. Reset clears all valid bits; data registers are not reset.
module quaternion_product_and_rotate
  import qpr_pkg::*;
#(
  parameter int FRAC_BITS = 24,
  parameter int WORD_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      func,
  input  logic signed [IN_BITS-1:0] a_w,
  input  logic signed [IN_BITS-1:0] a_x,
  input  logic signed [IN_BITS-1:0] a_y,
  input  logic signed [IN_BITS-1:0] a_z,
  input  logic signed [IN_BITS-1:0] b_w,
  input  logic signed [IN_BITS-1:0] b_x,
  input  logic signed [IN_BITS-1:0] b_y,
  input  logic signed [IN_BITS-1:0] b_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [IN_BITS-1:0] out_w,
  output logic signed [IN_BITS-1:0] out_x,
  output logic signed [IN_BITS-1:0] out_y,
  output logic signed [IN_BITS-1:0] out_z,
  output logic                      saturated
);

  // side band of pass 1: func and a, which pass 2 needs
  localparam int SB1 = 1 + 4*IN_BITS;
  // side band of pass 2: func, pass 1 result and its clip flag
  localparam int SB2 = 2 + 4*WORD_BITS;

  logic                        en;
  logic signed [IN_BITS-1:0]   p1_a [4];
  logic signed [IN_BITS-1:0]   p1_b [4];
  logic [SB1-1:0]              p1_side_in, p1_side;
  logic                        p1_valid;
  logic signed [WORD_BITS-1:0] t [4];
  logic [3:0]                  t_sat;
  logic signed [IN_BITS-1:0]   p2_b [4];
  logic [SB2-1:0]              p2_side_in, p2_side;
  logic                        p2_valid;
  logic signed [WORD_BITS-1:0] rot [4];
  logic [3:0]                  rot_sat;
  logic                        sel_func;
  logic                        sel_sat1;
  logic signed [WORD_BITS-1:0] prd [4];
  logic signed [WORD_BITS-1:0] res [4];
  logic                        res_sat;
  logic signed [IN_BITS-1:0]   res_out [4];

  // global advance: the output register empty or being drained
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // pass 1: t = a * b, with b_w forced to zero for rotation
  assign p1_a[0] = a_w;
  assign p1_a[1] = a_x;
  assign p1_a[2] = a_y;
  assign p1_a[3] = a_z;
  assign p1_b[0] = (func == FUNC_ROTATE) ? '0 : b_w;
  assign p1_b[1] = b_x;
  assign p1_b[2] = b_y;
  assign p1_b[3] = b_z;
  assign p1_side_in = {func, a_w, a_x, a_y, a_z};

  qpr_qmul #(
    .AW        (IN_BITS),
    .BW        (IN_BITS),
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS),
    .CONJ_B    (1'b0),
    .SBW       (SB1)
  ) u_pass1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid && in_ready),
    .a         (p1_a),
    .b         (p1_b),
    .in_side   (p1_side_in),
    .out_valid (p1_valid),
    .r         (t),
    .r_sat     (t_sat),
    .out_side  (p1_side)
  );

  // pass 2: r = t * conj(a); conjugation is folded into the term signs
  assign p2_b[0] = p1_side[4*IN_BITS-1 -: IN_BITS];
  assign p2_b[1] = p1_side[3*IN_BITS-1 -: IN_BITS];
  assign p2_b[2] = p1_side[2*IN_BITS-1 -: IN_BITS];
  assign p2_b[3] = p1_side[IN_BITS-1 -: IN_BITS];
  assign p2_side_in = {p1_side[SB1-1], t[0], t[1], t[2], t[3], |t_sat};

  qpr_qmul #(
    .AW        (WORD_BITS),
    .BW        (IN_BITS),
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS),
    .CONJ_B    (1'b1),
    .SBW       (SB2)
  ) u_pass2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p1_valid),
    .a         (t),
    .b         (p2_b),
    .in_side   (p2_side_in),
    .out_valid (p2_valid),
    .r         (rot),
    .r_sat     (rot_sat),
    .out_side  (p2_side)
  );

  // pick the result; rotation's scalar part is neither kept nor flagged
  assign sel_func = p2_side[SB2-1];
  assign sel_sat1 = p2_side[0];
  assign prd[0]   = p2_side[4*WORD_BITS -: WORD_BITS];
  assign prd[1]   = p2_side[3*WORD_BITS -: WORD_BITS];
  assign prd[2]   = p2_side[2*WORD_BITS -: WORD_BITS];
  assign prd[3]   = p2_side[WORD_BITS -: WORD_BITS];

  always_comb begin
    if (sel_func == FUNC_ROTATE) begin
      res[0]  = '0;
      res[1]  = rot[1];
      res[2]  = rot[2];
      res[3]  = rot[3];
      res_sat = sel_sat1 | (|rot_sat[3:1]);
    end else begin
      res     = prd;
      res_sat = sel_sat1;
    end
    // fit the word to the port: sign-extend a narrow word, truncate a wide one
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < IN_BITS; k++) begin
        res_out[c][k] = res[c][(k < WORD_BITS) ? k : WORD_BITS-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_w     <= res_out[0];
      out_x     <= res_out[1];
      out_y     <= res_out[2];
      out_z     <= res_out[3];
      saturated <= res_sat;
    end
  end

endmodule

// ===== hw/rtl/qpr_qmul.sv =====
// Four-stage pipelined Hamilton product with shift and saturate per component.
module qpr_qmul
  import qpr_pkg::*;
#(
  parameter int    AW        = 32,
  parameter int    BW        = 32,
  parameter int    FRAC_BITS = 24,
  parameter int    WORD_BITS = 32,
  parameter bit    CONJ_B    = 1'b0,
  parameter int    SBW       = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [AW-1:0]        a [4],
  input  logic signed [BW-1:0]        b [4],
  input  logic [SBW-1:0]              in_side,
  output logic                        out_valid,
  output logic signed [WORD_BITS-1:0] r [4],
  output logic [3:0]                  r_sat,
  output logic [SBW-1:0]              out_side
);

  localparam int PW = AW + BW;
  localparam int SW = PW + 2;

  logic signed [PW-1:0] prod [4][4];
  logic signed [PW:0]   term [4][4];
  logic signed [PW:0]   pair [4][2];
  logic signed [SW-1:0] sum  [4];
  logic signed [SW-1:0] shifted [4];
  logic                 v1, v2, v3;
  logic [SBW-1:0]       side1, side2, side3;

  // sign-adjusted terms, one bit wider so negation of any product is exact
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (term_neg(i, j, CONJ_B)) begin
          term[i][j] = -(PW+1)'(prod[i][j]);
        end else begin
          term[i][j] = (PW+1)'(prod[i][j]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      shifted[i] = sum[i] >>> FRAC_BITS;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      side1    <= in_side;
      side2    <= side1;
      side3    <= side2;
      out_side <= side3;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod[i][j] <= PW'(a[j]) * PW'(b[i ^ j]);
        end
        pair[i][0] <= term[i][0] + term[i][1];
        pair[i][1] <= term[i][2] + term[i][3];
        sum[i]     <= SW'(pair[i][0]) + SW'(pair[i][1]);
        // in range when all bits above the result's sign match it
        if ((shifted[i][SW-1:WORD_BITS-1] == '0) ||
            (shifted[i][SW-1:WORD_BITS-1] == '1)) begin
          r[i]     <= shifted[i][WORD_BITS-1:0];
          r_sat[i] <= 1'b0;
        end else begin
          r[i]     <= {shifted[i][SW-1], {(WORD_BITS-1){~shifted[i][SW-1]}}};
          r_sat[i] <= 1'b1;
        end
      end
    end
  end

endmodule
